/* hw/rtl/fragment_reassembler_macros.svh */
// assertion macros for the fragment reassembler
`ifndef FRAGMENT_REASSEMBLER_MACROS_SVH
`define FRAGMENT_REASSEMBLER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FR_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define FR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fr_pkg.sv */
// shared types and constants of the fragment reassembler
package fr_pkg;

    localparam int HDR_LEN = 12;
    localparam logic [7:0] MAGIC_A = 8'h47;
    localparam logic [7:0] MAGIC_B = 8'h53;
    localparam logic [7:0] WIRE_VERSION = 8'h01;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 64;
    localparam logic [CFG_AW-1:0] ADDR_TIMEOUT = 5'd0;
    localparam logic [CFG_AW-1:0] ADDR_KIND_FIRST = 5'd8;
    localparam logic [CFG_AW-1:0] ADDR_KIND_LAST = 5'd16;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [63:0] now_ms;
        logic [9:0]  read_address;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  msg_kind;
        logic [10:0] msg_length;
        logic [7:0]  read_data;
    } out_item_t;

    typedef struct packed {
        logic [63:0] expiry_ms;
        logic [7:0]  kind_first;
        logic [7:0]  kind_last;
    } cfg_t;

    // work handed from the parser to the assembly side
    typedef struct packed {
        logic        wr_en;
        logic        rd_en;
        logic        rd_in_range;
        logic        judge;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        ok;
        logic [31:0] trans;
        logic [7:0]  kind;
        logic [15:0] total;
        logic [7:0]  cnt;
        logic [7:0]  idx;
        logic [63:0] now;
        logic [63:0] deadline;
    } job_t;

endpackage

/* hw/rtl/fr_front.sv */
// packet parser: header capture, payload addressing and per-packet checks
module fr_front #(
    parameter int PACKET_BYTES = 64,
    parameter int MESSAGE_BYTES = 1024,
    parameter int MAX_FRAGMENTS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  fr_pkg::in_item_t item,
    input  fr_pkg::cfg_t     cfg,
    input  logic             job_full,
    output logic             job_push,
    output fr_pkg::job_t     job
);

    localparam int PL = PACKET_BYTES - fr_pkg::HDR_LEN;
    localparam int PW = $clog2(PACKET_BYTES + 1);

    logic [7:0]    hdr_reg [fr_pkg::HDR_LEN];
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic          over_reg;
    logic          over_next;

    logic          accept;
    logic          is_packet;
    logic          at_cap;
    logic          in_payload;
    logic [16:0]   waddr;
    logic          waddr_ok;
    logic [PW-1:0] len;
    logic [PW-1:0] part;
    logic          over;
    logic [64:0]   sum;
    logic [31:0]   trans;
    logic [15:0]   total;
    logic [16:0]   cnt_pl;
    logic [16:0]   off;
    logic [16:0]   room;
    logic [16:0]   room_cap;
    logic          want_ok;
    logic          bad;

    assign full = job_full;
    assign accept = push && !job_full;
    assign is_packet = (item.opcode == fr_pkg::OP_PACKET);
    assign at_cap = 32'(pos_reg) >= PACKET_BYTES;
    assign in_payload = !at_cap && (32'(pos_reg) >= fr_pkg::HDR_LEN);
    assign waddr = 17'(hdr_reg[8]) * 17'(PL) + 17'(pos_reg) - 17'(fr_pkg::HDR_LEN);
    assign waddr_ok = 32'(waddr) < MESSAGE_BYTES;
    assign len = at_cap ? pos_reg : pos_reg + PW'(1);
    assign part = len - PW'(fr_pkg::HDR_LEN);
    assign over = over_reg || at_cap;
    assign sum = {1'b0, item.now_ms} + {1'b0, cfg.expiry_ms};
    assign trans = {hdr_reg[7], hdr_reg[6], hdr_reg[5], hdr_reg[4]};
    assign total = {hdr_reg[11], hdr_reg[10]};
    assign cnt_pl = 17'(hdr_reg[9]) * 17'(PL);
    assign off = 17'(hdr_reg[8]) * 17'(PL);
    assign room = 17'(total) - off;
    assign room_cap = (room < 17'(PL)) ? room : 17'(PL);
    assign want_ok = (cnt_pl >= 17'(total)) && ((cnt_pl - 17'(PL)) < 17'(total));

    always_comb
    begin
        bad = over
            || (32'(len) <= fr_pkg::HDR_LEN)
            || (32'(len) > PACKET_BYTES)
            || (hdr_reg[0] != fr_pkg::MAGIC_A)
            || (hdr_reg[1] != fr_pkg::MAGIC_B)
            || (hdr_reg[2] != fr_pkg::WIRE_VERSION)
            || (hdr_reg[3] < cfg.kind_first)
            || (hdr_reg[3] > cfg.kind_last)
            || (cfg.expiry_ms == 64'd0)
            || sum[64]
            || (trans == 32'd0)
            || (total == 16'd0)
            || (32'(total) > MESSAGE_BYTES)
            || (hdr_reg[9] == 8'd0)
            || (32'(hdr_reg[9]) > MAX_FRAGMENTS)
            || !want_ok
            || (hdr_reg[8] >= hdr_reg[9])
            || (off >= 17'(total))
            || (17'(part) != room_cap);
    end

    always_comb
    begin
        job = '0;
        job.data = item.data_byte;
        job.trans = trans;
        job.kind = hdr_reg[3];
        job.total = total;
        job.cnt = hdr_reg[9];
        job.idx = hdr_reg[8];
        job.now = item.now_ms;
        job.deadline = sum[63:0];
        job.ok = !bad;
        if (is_packet)
        begin
            job.wr_en = in_payload && waddr_ok;
            job.addr = waddr[15:0];
            job.judge = item.last_byte;
        end
        else
        begin
            job.rd_en = 1'b1;
            job.rd_in_range = 32'(item.read_address) < MESSAGE_BYTES;
            job.addr = 16'(item.read_address);
        end
        job_push = accept && (job.rd_en || job.wr_en || job.judge);
    end

    always_comb
    begin
        pos_next = pos_reg;
        over_next = over_reg;
        if (accept && is_packet)
        begin
            if (at_cap)
            begin
                over_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + PW'(1);
            end
            if (item.last_byte)
            begin
                pos_next = '0;
                over_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            over_reg <= 1'b0;
            for (int i = 0; i < fr_pkg::HDR_LEN; i++)
            begin
                hdr_reg[i] <= 8'd0;
            end
        end
        else
        begin
            pos_reg <= pos_next;
            over_reg <= over_next;
            if (accept && is_packet && !at_cap && (32'(pos_reg) < fr_pkg::HDR_LEN))
            begin
                hdr_reg[pos_reg[3:0]] <= item.data_byte;
            end
        end
    end

endmodule

/* hw/rtl/fr_queue.sv */
// short job queue between parser and assembly side
module fr_queue #(
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  fr_pkg::job_t din,
    output logic         full,
    input  logic         pop,
    output fr_pkg::job_t dout,
    output logic         empty
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fr_pkg::job_t  mem_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full = (32'(count_reg) == DEPTH);
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign dout = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTRW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTRW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

/* hw/rtl/fr_back.sv */
// assembly side: message store, assembly state and result queue
module fr_back #(
    parameter int MESSAGE_BYTES = 1024,
    parameter int MAX_FRAGMENTS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_empty,
    input  fr_pkg::job_t      job,
    output logic              job_pop,
    output logic              empty,
    input  logic              pop,
    output fr_pkg::out_item_t result
);

    localparam int AW = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
    localparam int FW = $clog2(MAX_FRAGMENTS + 1);
    localparam int OD = 4;
    localparam int OPW = $clog2(OD);
    localparam int OCW = $clog2(OD + 1);

    logic [7:0] store [MESSAGE_BYTES];
    logic [7:0] mem_q_reg;

    logic [31:0]   open_trans_reg, open_trans_next;
    logic [7:0]    open_kind_reg, open_kind_next;
    logic [15:0]   open_total_reg, open_total_next;
    logic [FW-1:0] exp_cnt_reg, exp_cnt_next;
    logic [FW-1:0] next_idx_reg, next_idx_next;
    logic [63:0]   deadline_reg, deadline_next;

    logic          res_valid_reg, res_valid_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [7:0]    res_kind_reg, res_kind_next;
    logic [10:0]   res_len_reg, res_len_next;
    logic          res_read_ok_reg, res_read_ok_next;

    fr_pkg::out_item_t out_mem_reg [OD];
    logic [OPW-1:0] owr_ptr_reg;
    logic [OPW-1:0] ord_ptr_reg;
    logic [OCW-1:0] ocount_reg;
    logic           out_pop;
    fr_pkg::out_item_t res_item;

    logic          take;
    logic          expired;
    logic          start;
    logic          mismatch;
    logic [31:0]   e_trans;
    logic [7:0]    e_kind;
    logic [15:0]   e_total;
    logic [FW-1:0] e_exp;
    logic [FW-1:0] e_next;
    logic [63:0]   e_deadline;
    logic [FW-1:0] ni;

    // hold a job back while the result queue could overflow
    assign take = !job_empty && ((32'(ocount_reg) + 32'(res_valid_reg)) < OD);
    assign job_pop = take;

    always_ff @(posedge clk)
    begin
        if (take && job.wr_en)
        begin
            store[job.addr[AW-1:0]] <= job.data;
        end
        if (take && job.rd_en)
        begin
            mem_q_reg <= store[job.addr[AW-1:0]];
        end
    end

    always_comb
    begin
        expired = (next_idx_reg != '0) && (job.now > deadline_reg);
        e_trans = expired ? 32'd0 : open_trans_reg;
        e_kind = expired ? 8'd0 : open_kind_reg;
        e_total = expired ? 16'd0 : open_total_reg;
        e_exp = expired ? '0 : exp_cnt_reg;
        e_next = expired ? '0 : next_idx_reg;
        e_deadline = expired ? 64'd0 : deadline_reg;
        start = (job.idx == 8'd0) && (e_next == '0);
        if (start)
        begin
            e_trans = job.trans;
            e_kind = job.kind;
            e_total = job.total;
            e_exp = FW'(job.cnt);
            e_deadline = job.deadline;
        end
        mismatch = (e_exp == '0) || (job.trans != e_trans) || (job.kind != e_kind)
            || (job.total != e_total) || (job.cnt != 8'(e_exp)) || (job.idx != 8'(e_next));
        ni = e_next + FW'(1);

        open_trans_next = open_trans_reg;
        open_kind_next = open_kind_reg;
        open_total_next = open_total_reg;
        exp_cnt_next = exp_cnt_reg;
        next_idx_next = next_idx_reg;
        deadline_next = deadline_reg;
        res_valid_next = take && (job.rd_en || job.judge);
        res_status_next = fr_pkg::ST_READ;
        res_kind_next = 8'd0;
        res_len_next = 11'd0;
        res_read_ok_next = job.rd_en && job.rd_in_range;

        if (take && job.judge)
        begin
            open_trans_next = 32'd0;
            open_kind_next = 8'd0;
            open_total_next = 16'd0;
            exp_cnt_next = '0;
            next_idx_next = '0;
            deadline_next = 64'd0;
            res_status_next = fr_pkg::ST_REJECT;
            if (job.ok && !mismatch)
            begin
                if (ni != e_exp)
                begin
                    open_trans_next = e_trans;
                    open_kind_next = e_kind;
                    open_total_next = e_total;
                    exp_cnt_next = e_exp;
                    next_idx_next = ni;
                    deadline_next = e_deadline;
                    res_status_next = fr_pkg::ST_MORE;
                end
                else
                begin
                    res_status_next = fr_pkg::ST_COMPLETE;
                    res_kind_next = e_kind;
                    res_len_next = e_total[10:0];
                end
            end
        end
    end

    always_comb
    begin
        res_item.status = res_status_reg;
        res_item.msg_kind = res_kind_reg;
        res_item.msg_length = res_len_reg;
        res_item.read_data = res_read_ok_reg ? mem_q_reg : 8'd0;
    end

    assign empty = (ocount_reg == '0);
    assign out_pop = pop && !empty;
    assign result = out_mem_reg[ord_ptr_reg];

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_kind_reg <= res_kind_next;
        res_len_reg <= res_len_next;
        res_read_ok_reg <= res_read_ok_next;
        if (res_valid_reg)
        begin
            out_mem_reg[owr_ptr_reg] <= res_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_trans_reg <= 32'd0;
            open_kind_reg <= 8'd0;
            open_total_reg <= 16'd0;
            exp_cnt_reg <= '0;
            next_idx_reg <= '0;
            deadline_reg <= 64'd0;
            res_valid_reg <= 1'b0;
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg <= '0;
        end
        else
        begin
            open_trans_reg <= open_trans_next;
            open_kind_reg <= open_kind_next;
            open_total_reg <= open_total_next;
            exp_cnt_reg <= exp_cnt_next;
            next_idx_reg <= next_idx_next;
            deadline_reg <= deadline_next;
            res_valid_reg <= res_valid_next;
            if (res_valid_reg)
            begin
                owr_ptr_reg <= owr_ptr_reg + OPW'(1);
            end
            if (out_pop)
            begin
                ord_ptr_reg <= ord_ptr_reg + OPW'(1);
            end
            if (res_valid_reg && !out_pop)
            begin
                ocount_reg <= ocount_reg + OCW'(1);
            end
            else if (out_pop && !res_valid_reg)
            begin
                ocount_reg <= ocount_reg - OCW'(1);
            end
        end
    end

endmodule

/* hw/rtl/fragment_reassembler.sv */
// Fragment reassembler top level: takes one packet byte or read request per cycle
// (push while full is low) and rebuilds a message from fragment packets. The
// parser handles every item as it is accepted; a result (on a packet's last byte or a
// read) passes through the job queue and the result stage, which also holds the
// registered read port of the single-port message store, before it enters the result
// queue. Sustained rate is one item per cycle while results are popped. Message
// store contents are undefined after reset until written.
`include "fragment_reassembler_macros.svh"

module fragment_reassembler #(
    parameter int PACKET_BYTES = 64,
    parameter int MESSAGE_BYTES = 1024,
    parameter int MAX_FRAGMENTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  fr_pkg::in_item_t              item,
    output logic                          empty,
    input  logic                          pop,
    output fr_pkg::out_item_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fr_pkg::CFG_AW-1:0]     paddr,
    input  logic [fr_pkg::CFG_DW-1:0]     pwdata,
    output logic [fr_pkg::CFG_DW-1:0]     prdata,
    output logic                          pready
);

    fr_pkg::cfg_t cfg_reg;
    fr_pkg::job_t front_job;
    fr_pkg::job_t back_job;
    logic         cfg_wr;
    logic         job_push;
    logic         job_full;
    logic         job_pop;
    logic         job_empty;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expiry_ms <= 64'd5000;
            cfg_reg.kind_first <= 8'd1;
            cfg_reg.kind_last <= 8'd9;
        end
        else if (cfg_wr)
        begin
            case (paddr)
                fr_pkg::ADDR_TIMEOUT:    cfg_reg.expiry_ms <= pwdata;
                fr_pkg::ADDR_KIND_FIRST: cfg_reg.kind_first <= pwdata[7:0];
                fr_pkg::ADDR_KIND_LAST:  cfg_reg.kind_last <= pwdata[7:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            fr_pkg::ADDR_TIMEOUT:    prdata = cfg_reg.expiry_ms;
            fr_pkg::ADDR_KIND_FIRST: prdata = 64'(cfg_reg.kind_first);
            fr_pkg::ADDR_KIND_LAST:  prdata = 64'(cfg_reg.kind_last);
            default:                 prdata = '0;
        endcase
    end

    fr_front #(
        .PACKET_BYTES(PACKET_BYTES),
        .MESSAGE_BYTES(MESSAGE_BYTES),
        .MAX_FRAGMENTS(MAX_FRAGMENTS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .cfg(cfg_reg),
        .job_full(job_full),
        .job_push(job_push),
        .job(front_job)
    );

    fr_queue #(
        .DEPTH(4)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(job_push),
        .din(front_job),
        .full(job_full),
        .pop(job_pop),
        .dout(back_job),
        .empty(job_empty)
    );

    fr_back #(
        .MESSAGE_BYTES(MESSAGE_BYTES),
        .MAX_FRAGMENTS(MAX_FRAGMENTS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .job_empty(job_empty),
        .job(back_job),
        .job_pop(job_pop),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    `FR_ASSERT_IMPLY(a_kind_only_complete, clk, rst_n, !empty && (result.status != fr_pkg::ST_COMPLETE), (result.msg_kind == 8'd0) && (result.msg_length == 11'd0), "kind or length set without completion")
    `FR_ASSERT_IMPLY(a_data_only_read, clk, rst_n, !empty && (result.status != fr_pkg::ST_READ), result.read_data == 8'd0, "read data set on a non-read result")
    `FR_ASSERT_NEXT(a_expiry_write, clk, rst_n, cfg_wr && (paddr == fr_pkg::ADDR_TIMEOUT), cfg_reg.expiry_ms == $past(pwdata), "expiry register not written")

endmodule

/* dv/tb_fragment_reassembler.sv */
// self-checking testbench for the fragment reassembler: byte stream stimulus, predicted results
module tb_fragment_reassembler;

    localparam int PKT_BYTES = 64;
    localparam int MSG_BYTES = 1024;
    localparam int MAX_FRAG = 32;
    localparam int HDR = fr_pkg::HDR_LEN;
    localparam int PAY_LEN = PKT_BYTES - HDR;
    localparam int ITEM_TARGET = 1600;
    localparam int STALL_CYCLES = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    fr_pkg::in_item_t item = '0;
    logic empty;
    logic pop = 1'b0;
    fr_pkg::out_item_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [fr_pkg::CFG_AW-1:0] paddr = '0;
    logic [fr_pkg::CFG_DW-1:0] pwdata = '0;
    logic [fr_pkg::CFG_DW-1:0] prdata;
    logic pready;

    fragment_reassembler dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic [63:0] cfg_expiry;
    logic [7:0] cfg_kfirst, cfg_klast;
    logic [7:0] hdr [HDR];
    int unsigned pos;
    bit overlong;
    logic [31:0] asm_trans;
    logic [7:0] asm_kind;
    logic [15:0] asm_total;
    int unsigned asm_count, asm_next;
    logic [63:0] asm_deadline;
    logic [7:0] store [MSG_BYTES];
    bit written [MSG_BYTES];

    fr_pkg::in_item_t pending_items [$];
    fr_pkg::out_item_t expected_results [$];
    int errors = 0;
    int queued = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    bit stall_req = 1'b0;
    int hold_left = 0;
    logic hold_rx;

    assign hold_rx = (hold_left != 0);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void clear_asm();
        asm_trans = '0;
        asm_kind = '0;
        asm_total = '0;
        asm_count = 0;
        asm_next = 0;
        asm_deadline = '0;
    endfunction

    function automatic logic [1:0] judge_packet(int unsigned len, bit over, logic [63:0] now,
                                                output logic [7:0] okind,
                                                output logic [10:0] olen);
        logic [31:0] trans;
        int unsigned idx, cnt, total, want, off, part, room;
        okind = '0;
        olen = '0;
        if (over || len <= HDR || len > PKT_BYTES || hdr[0] != fr_pkg::MAGIC_A ||
            hdr[1] != fr_pkg::MAGIC_B || hdr[2] != fr_pkg::WIRE_VERSION ||
            hdr[3] < cfg_kfirst || hdr[3] > cfg_klast || cfg_expiry == 0 ||
            now > ~cfg_expiry)
        begin
            clear_asm();
            return fr_pkg::ST_REJECT;
        end
        trans = {hdr[7], hdr[6], hdr[5], hdr[4]};
        idx = hdr[8];
        cnt = hdr[9];
        total = {hdr[11], hdr[10]};
        want = (total + PAY_LEN - 1) / PAY_LEN;
        off = idx * PAY_LEN;
        part = len - HDR;
        if (trans == 0 || total == 0 || total > MSG_BYTES || cnt == 0 || cnt > MAX_FRAG ||
            cnt != want || idx >= cnt || off >= total)
        begin
            clear_asm();
            return fr_pkg::ST_REJECT;
        end
        room = total - off;
        if (part != ((room < PAY_LEN) ? room : PAY_LEN))
        begin
            clear_asm();
            return fr_pkg::ST_REJECT;
        end
        if (asm_next != 0 && now > asm_deadline)
            clear_asm();
        if (idx == 0 && asm_next == 0)
        begin
            asm_trans = trans;
            asm_kind = hdr[3];
            asm_total = 16'(total);
            asm_count = cnt;
            asm_deadline = now + cfg_expiry;
        end
        if (asm_count == 0 || trans != asm_trans || hdr[3] != asm_kind ||
            total != asm_total || cnt != asm_count || idx != asm_next)
        begin
            clear_asm();
            return fr_pkg::ST_REJECT;
        end
        asm_next++;
        if (asm_next != asm_count)
            return fr_pkg::ST_MORE;
        okind = asm_kind;
        olen = asm_total[10:0];
        clear_asm();
        return fr_pkg::ST_COMPLETE;
    endfunction

    // returns 1 when the item produces a result
    function automatic bit predict_item(fr_pkg::in_item_t it, output fr_pkg::out_item_t res);
        int unsigned addr, len;
        bit over;
        res = '0;
        if (it.opcode == fr_pkg::OP_READ)
        begin
            res.status = fr_pkg::ST_READ;
            res.read_data = (it.read_address < MSG_BYTES) ? store[it.read_address] : 8'h00;
            return 1'b1;
        end
        if (pos >= PKT_BYTES)
            overlong = 1'b1;
        else
        begin
            if (pos < HDR)
                hdr[pos] = it.data_byte;
            else
            begin
                addr = hdr[8] * PAY_LEN + (pos - HDR);
                if (addr < MSG_BYTES)
                begin
                    store[addr] = it.data_byte;
                    written[addr] = 1'b1;
                end
            end
            pos++;
        end
        if (!it.last_byte)
            return 1'b0;
        len = pos;
        over = overlong;
        pos = 0;
        overlong = 1'b0;
        res.status = judge_packet(len, over, it.now_ms, res.msg_kind, res.msg_length);
        return 1'b1;
    endfunction

    logic [63:0] clock_ms;

    // queue one item for the driver and predict its result
    task automatic post_item(fr_pkg::in_item_t it);
        fr_pkg::out_item_t res;
        pending_items = {pending_items, it};
        queued++;
        if (predict_item(it, res))
            expected_results = {expected_results, res};
    endtask

    task automatic queue_byte(logic [7:0] b, bit last);
        fr_pkg::in_item_t it;
        it = '0;
        it.opcode = fr_pkg::OP_PACKET;
        it.data_byte = b;
        it.last_byte = last;
        it.now_ms = last ? clock_ms : {$urandom, $urandom};
        it.read_address = 10'($urandom_range(0, 1023));
        post_item(it);
    endtask

    task automatic queue_read(int addr);
        fr_pkg::in_item_t it;
        it = '0;
        it.opcode = fr_pkg::OP_READ;
        it.data_byte = 8'($urandom);
        it.last_byte = 1'($urandom);
        it.now_ms = {$urandom, $urandom};
        it.read_address = 10'(addr);
        post_item(it);
    endtask

    // read a random address already written
    task automatic queue_safe_read();
        int a, tries;
        tries = 0;
        a = $urandom_range(0, MSG_BYTES - 1);
        while (!written[a] && tries < 50)
        begin
            a = $urandom_range(0, MSG_BYTES - 1);
            tries++;
        end
        if (written[a])
            queue_read(a);
    endtask

    // one fragment packet, with an occasional read mixed in
    task automatic queue_fragment(logic [31:0] trans, logic [7:0] kind, int idx, int cnt,
                                  int total, int plen, bit corrupt);
        logic [7:0] h [HDR];
        int n, k;
        h[0] = fr_pkg::MAGIC_A;
        h[1] = fr_pkg::MAGIC_B;
        h[2] = fr_pkg::WIRE_VERSION;
        h[3] = kind;
        {h[7], h[6], h[5], h[4]} = trans;
        h[8] = 8'(idx);
        h[9] = 8'(cnt);
        {h[11], h[10]} = 16'(total);
        if (corrupt)
        begin
            k = $urandom_range(0, HDR - 1);
            h[k] = h[k] ^ (8'h1 << $urandom_range(0, 7));
        end
        n = HDR + plen;
        for (int i = 0; i < n; i++)
        begin
            queue_byte((i < HDR) ? h[i] : 8'($urandom), i == n - 1);
            if ($urandom_range(0, 29) == 0)
                queue_safe_read();
        end
    endtask

    task automatic queue_message(logic [7:0] kind, int total, int mode);
        logic [31:0] trans;
        int cnt, room, plen, skip;
        trans = $urandom_range(1, 32'hffff_ffff);
        cnt = (total + PAY_LEN - 1) / PAY_LEN;
        skip = (mode == 1) ? $urandom_range(0, cnt - 1) : -1;
        for (int i = 0; i < cnt; i++)
        begin
            room = total - i * PAY_LEN;
            plen = (room < PAY_LEN) ? room : PAY_LEN;
            if (i == skip)
                continue;
            if (mode == 2 && $urandom_range(0, cnt) == 0)
                plen = $urandom_range(0, PAY_LEN + 6);
            queue_fragment(trans, kind, i, cnt, total, plen,
                           mode == 3 && $urandom_range(0, cnt) == 0);
            clock_ms = clock_ms + 64'($urandom_range(0, 40));
        end
    endtask

    // random bytes, ending on a last byte so the next packet starts clean
    task automatic queue_noise(int n);
        for (int i = 0; i < n; i++)
            queue_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 7) == 0));
    endtask

    task automatic apb_write(logic [fr_pkg::CFG_AW-1:0] a, logic [63:0] d);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(logic [63:0] t, logic [7:0] kf, logic [7:0] kl);
        apb_write(fr_pkg::ADDR_TIMEOUT, t);
        apb_write(fr_pkg::ADDR_KIND_FIRST, {56'h0, kf});
        apb_write(fr_pkg::ADDR_KIND_LAST, {56'h0, kl});
        cfg_expiry = t;
        cfg_kfirst = kf;
        cfg_klast = kl;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin : drive_proc
        bit accepted;
        int gap;
        if (rst_n)
        begin
            accepted = push && !full;
            if (accepted)
                void'(pending_items.pop_front());
            if (!push || accepted)
            begin
                gap = accepted ? pick_gap() : tx_gap;
                if (gap == 0 && pending_items.size() != 0)
                begin
                    push <= 1'b1;
                    item <= pending_items[0];
                    tx_gap <= 0;
                end
                else
                begin
                    push <= 1'b0;
                    tx_gap <= (gap > 0) ? gap - 1 : 0;
                end
            end
        end
    end

    // receiver stall counter
    always @(posedge clk)
    begin
        if (stall_req)
            hold_left <= STALL_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor and receiver
    always @(posedge clk)
    begin : monitor_proc
        fr_pkg::out_item_t exp_r;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result %p", $time, result);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result.status !== exp_r.status)
                    begin
                        $display("%0t status expected %0d actual %0d", $time,
                                 exp_r.status, result.status);
                        errors++;
                    end
                    if (result.msg_kind !== exp_r.msg_kind)
                    begin
                        $display("%0t msg_kind expected %0h actual %0h", $time,
                                 exp_r.msg_kind, result.msg_kind);
                        errors++;
                    end
                    if (result.msg_length !== exp_r.msg_length)
                    begin
                        $display("%0t msg_length expected %0d actual %0d", $time,
                                 exp_r.msg_length, result.msg_length);
                        errors++;
                    end
                    if (result.read_data !== exp_r.read_data)
                    begin
                        $display("%0t read_data expected %0h actual %0h", $time,
                                 exp_r.read_data, result.read_data);
                        errors++;
                    end
                end
            end
            if (hold_rx)
                pop <= 1'b0;
            else if (rx_gap > 0)
            begin
                pop <= 1'b0;
                rx_gap <= rx_gap - 1;
            end
            else
            begin
                pop <= 1'b1;
                if (pop && !empty)
                    rx_gap <= pick_gap();
            end
        end
    end

    initial
    begin : stim_proc
        int sz, mode, base, target, kind;
        cfg_expiry = 64'd5000;
        cfg_kfirst = 8'd1;
        cfg_klast = 8'd9;
        pos = 0;
        overlong = 1'b0;
        clear_asm();
        for (int i = 0; i < HDR; i++)
            hdr[i] = '0;
        for (int i = 0; i < MSG_BYTES; i++)
            written[i] = 1'b0;
        clock_ms = 64'd100;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset config, one-fragment and multi-fragment messages
        queue_message(8'd1, 1, 0);
        queue_read(0);
        queue_message(8'd9, 2 * PAY_LEN + 5, 0);
        queue_noise(3);
        drain();

        // config extremes: full kind range, huge expiry overflowing, zero expiry
        set_config(64'hffff_ffff_ffff_ffff, 8'd0, 8'd255);
        queue_message(8'd0, 10, 0);
        drain();
        set_config(64'd0, 8'd0, 8'd255);
        queue_message(8'd255, 10, 0);
        drain();
        set_config(64'd30, 8'd4, 8'd4);
        queue_message(8'd4, 4 * PAY_LEN, 0);
        queue_fragment(32'd77, 8'd4, MSG_BYTES / PAY_LEN, (MSG_BYTES + PAY_LEN - 1) / PAY_LEN,
                       MSG_BYTES, MSG_BYTES - (MSG_BYTES / PAY_LEN) * PAY_LEN, 1'b0);
        queue_message(8'd5, 20, 0);
        queue_message(8'd4, 3 * PAY_LEN, 2);
        queue_noise(PKT_BYTES + 10);
        queue_noise(2);
        queue_read(MSG_BYTES - 1);
        drain();

        // long receiver stall while the sender keeps offering
        set_config(64'd5000, 8'd1, 8'd9);
        @(posedge clk);
        stall_req <= 1'b1;
        @(posedge clk);
        stall_req <= 1'b0;
        for (int i = 0; i < 60; i++)
            queue_read(0);
        drain();

        base = queued;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_config(64'd5000, 8'd1, 8'd9);
                1: set_config(64'd60, 8'd0, 8'd255);
                2: set_config(64'd1, 8'd3, 8'd200);
                default: set_config(64'hffff_ffff_0000_0000, 8'd2, 8'd2);
            endcase
            if (phase == 3)
                clock_ms = 64'hffff_fffe_ffff_ff00;
            target = base + (phase + 1) * (ITEM_TARGET - base) / 4;
            do
            begin
                sz = ($urandom_range(0, 19) == 0) ? $urandom_range(1, MSG_BYTES)
                                                  : $urandom_range(1, 3 * PAY_LEN);
                mode = $urandom_range(0, 9);
                mode = (mode < 6) ? 0 : mode - 6;
                kind = $urandom_range(cfg_kfirst, cfg_klast);
                queue_message(8'(kind), sz, mode);
                if ($urandom_range(0, 3) == 0)
                    queue_noise($urandom_range(1, 20));
                while (pending_items.size() > 64)
                    @(posedge clk);
            end
            while (queued < target);
            drain();
        end
        if (errors == 0 && expected_results.size() == 0)
            $display("[fragment_reassembler] OK");
        else
            $display("[fragment_reassembler] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[fragment_reassembler] ERROR");
        $finish;
    end

endmodule
